// ----- src/frv_pkg.sv -----
// ----------------------------------------------------------------------------
// frv_pkg: shared definitions of the frame rms volume unit
// widths, register map, sequencer states and shared-unit operations
// ----------------------------------------------------------------------------
package frv_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_HOP     = 4096;
  localparam int HOP_BITS    = 13;
  localparam int HOP_RESET   = 512;
  localparam int SUM_BITS    = 42;
  localparam int SQ_BITS     = 2 * SAMPLE_BITS;
  localparam int VOL_BITS    = 16;
  localparam int VOL_MAX     = 1 << (SAMPLE_BITS - 1);

  // square root works two bits of the mean per step
  localparam int ROOT_BITS   = SUM_BITS / 2;
  localparam int REM_BITS    = ROOT_BITS + 1;
  localparam int UNIT_BITS   = REM_BITS + 2;
  localparam int CNT_BITS    = 6;
  localparam int DIV_LAST    = SUM_BITS - 1;
  localparam int SQRT_LAST   = ROOT_BITS - 1;

  // apb register map
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam int REG_SEL_BIT   = 2;
  localparam logic REG_HOP_SIZE = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_FIRST,
    ST_DIV,
    ST_SQRT,
    ST_ROUND,
    ST_MARK
  } frv_state_t;

  typedef enum logic [1:0] {
    OP_DIV,
    OP_SQRT,
    OP_ROUND
  } frv_op_t;

endpackage

// ----- src/frv_if.sv -----
// ----------------------------------------------------------------------------
// frv_if: stream channels of the frame rms volume unit
// sample channel in, volume result channel out, valid/ready handshake
// ----------------------------------------------------------------------------
interface frv_sample_if import frv_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          stream_last;

  modport source (output valid, output sample, output stream_last, input ready);
  modport sink (input valid, input sample, input stream_last, output ready);
endinterface

interface frv_result_if import frv_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VOL_BITS-1:0] volume;
  logic                is_frame;
  logic                end_of_stream;

  modport source (output valid, output volume, output is_frame, output end_of_stream,
                  input ready);
  modport sink (input valid, input volume, input is_frame, input end_of_stream,
                output ready);
endinterface

// ----- src/frame_rms_volume_unit.sv -----
// ----------------------------------------------------------------------------
// frame_rms_volume_unit: framed rms envelope of a signed audio stream
// one rms volume per frame of hop_size samples, iterative divide and root
// ----------------------------------------------------------------------------
// Samples (Q1.15) come in on the sample channel, one transaction at a time;
// the first sample of each stream gives frame 0 at once, equal to its
// magnitude, and every complete hop of samples then gives the rounded square
// root of the mean of its squares (unsigned Q1.15, at most 32768). The sample
// marked stream_last ends the stream: a partial frame is dropped, the final
// result carries end_of_stream, and a bare marker (is_frame 0, volume 0) goes
// out when that sample neither opened the stream nor closed a frame. A sample
// that completes no frame passes through accept, square and accumulate; one
// that completes a frame then runs a restoring division by the hop and a
// square root, both on the single shared 24-bit subtractor, and a rounding
// step; frame 0 and the end marker each add a step, and a result register
// that is still full adds a wait. The input is not ready while a sample is in
// work. hop_size is written over the APB port at byte address 0, which keeps
// its low 13 bits; 0 acts as 1 and values above 4096 act as 4096.
module frame_rms_volume_unit import frv_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  frv_sample_if.sink               samples,
  frv_result_if.source             results,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  // configuration
  logic [HOP_BITS-1:0] hop_size;
  logic [HOP_BITS-1:0] hop_eff;

  // stream state
  logic [SUM_BITS-1:0] square_sum;
  logic [HOP_BITS-1:0] frame_fill;
  logic                stream_start;

  // per-sample working registers
  logic [SAMPLE_BITS-1:0] mag;
  logic [SQ_BITS-1:0]     square;
  logic                   last_q;
  logic                   done_q;
  logic [HOP_BITS-1:0]    hop_q;

  // shared unit registers: num holds the dividend, then quotient, then mean
  logic [SUM_BITS-1:0]  num;
  logic [REM_BITS-1:0]  rem;
  logic [ROOT_BITS-1:0] root;
  logic [CNT_BITS-1:0]  cnt;

  frv_state_t state;
  frv_state_t state_next;
  frv_op_t    unit_op;

  // combinational helpers
  logic [SAMPLE_BITS:0]   sext;
  logic [SAMPLE_BITS:0]   mag_full;
  logic [SUM_BITS:0]      sum_wide;
  logic [SUM_BITS-1:0]    sum_sat;
  logic [HOP_BITS-1:0]    fill_inc;
  logic                   frame_done;
  logic [UNIT_BITS-1:0]   unit_a;
  logic [UNIT_BITS-1:0]   unit_b;
  logic [UNIT_BITS:0]     unit_diff;
  logic                   unit_ge;
  logic                   round_up;
  logic [VOL_BITS-1:0]    vol_final;
  logic                   out_free;
  logic                   out_load;
  logic [VOL_BITS-1:0]    out_vol;
  logic                   out_frame;
  logic                   out_eos;
  logic                   cfg_write;

  // ---------------------------------------------------------------- apb port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[REG_SEL_BIT] == REG_HOP_SIZE) ? APB_DATA_BITS'(hop_size)
                                                          : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      hop_size <= HOP_BITS'(HOP_RESET);
    end else if (cfg_write && paddr[REG_SEL_BIT] == REG_HOP_SIZE) begin
      hop_size <= pwdata[HOP_BITS-1:0];
    end
  end

  // zero hop acts as one, oversize hop is clamped
  always_comb begin
    if (hop_size == '0) begin
      hop_eff = HOP_BITS'(1);
    end else if (hop_size > HOP_BITS'(MAX_HOP)) begin
      hop_eff = HOP_BITS'(MAX_HOP);
    end else begin
      hop_eff = hop_size;
    end
  end

  // ---------------------------------------------------------------- datapath
  // magnitude of a two's complement sample, -32768 gives 32768
  assign sext     = {samples.sample[SAMPLE_BITS-1], samples.sample};
  assign mag_full = samples.sample[SAMPLE_BITS-1] ? (~sext + 1'b1) : sext;

  // saturating accumulate of the square
  assign sum_wide   = {1'b0, square_sum} + (SUM_BITS + 1)'(square);
  assign sum_sat    = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
  assign fill_inc   = frame_fill + 1'b1;
  assign frame_done = (fill_inc >= hop_eff);

  // shared compare-and-subtract unit
  always_comb begin
    case (unit_op)
      OP_DIV: begin
        unit_a = UNIT_BITS'({rem[HOP_BITS-1:0], num[SUM_BITS-1]});
        unit_b = UNIT_BITS'(hop_q);
      end
      OP_SQRT: begin
        unit_a = {rem, num[SUM_BITS-1 -: 2]};
        unit_b = UNIT_BITS'({root, 2'b01});
      end
      OP_ROUND: begin
        // root < remainder means the mean lies nearer the next integer
        unit_a = UNIT_BITS'(root);
        unit_b = UNIT_BITS'(rem);
      end
      default: begin
        unit_a = '0;
        unit_b = '0;
      end
    endcase
  end

  assign unit_diff = {1'b0, unit_a} - {1'b0, unit_b};
  assign unit_ge   = !unit_diff[UNIT_BITS];
  assign round_up  = !unit_ge;

  // saturate the rounded root at full scale
  assign vol_final = (root >= ROOT_BITS'(VOL_MAX)) ? VOL_BITS'(VOL_MAX)
                                                  : root[VOL_BITS-1:0] + VOL_BITS'(round_up);

  assign out_free = !results.valid || results.ready;

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (samples.valid) state_next = ST_SQUARE;
      end
      ST_SQUARE: state_next = ST_ACCUM;
      ST_ACCUM: begin
        if (stream_start) begin
          state_next = ST_FIRST;
        end else if (frame_done) begin
          state_next = ST_DIV;
        end else if (last_q) begin
          state_next = ST_MARK;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_FIRST: begin
        if (out_free) state_next = done_q ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (cnt == CNT_BITS'(DIV_LAST)) state_next = ST_SQRT;
      end
      ST_SQRT: begin
        if (cnt == CNT_BITS'(SQRT_LAST)) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_MARK: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    samples.ready = 1'b0;
    out_load      = 1'b0;
    out_vol       = '0;
    out_frame     = 1'b0;
    out_eos       = 1'b0;
    unit_op       = OP_DIV;
    case (state)
      ST_IDLE: samples.ready = 1'b1;
      ST_FIRST: begin
        // frame 0 is the magnitude itself; it ends the stream if nothing follows
        out_load  = out_free;
        out_vol   = mag;
        out_frame = 1'b1;
        out_eos   = last_q && !done_q;
      end
      ST_DIV: unit_op = OP_DIV;
      ST_SQRT: unit_op = OP_SQRT;
      ST_ROUND: begin
        unit_op   = OP_ROUND;
        out_load  = out_free;
        out_vol   = vol_final;
        out_frame = 1'b1;
        out_eos   = last_q;
      end
      ST_MARK: begin
        out_load = out_free;
        out_eos  = 1'b1;
      end
      default: begin
        samples.ready = 1'b0;
      end
    endcase
  end

  // stream state and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum   <= '0;
      frame_fill   <= '0;
      stream_start <= 1'b1;
    end else if (state == ST_ACCUM) begin
      if (frame_done || last_q) begin
        square_sum <= '0;
        frame_fill <= '0;
      end else begin
        square_sum <= sum_sat;
        frame_fill <= fill_inc;
      end
      stream_start <= last_q;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (samples.valid) begin
          mag    <= mag_full[SAMPLE_BITS-1:0];
          last_q <= samples.stream_last;
        end
      end
      ST_SQUARE: square <= mag * mag;
      ST_ACCUM: begin
        done_q <= frame_done;
        hop_q  <= hop_eff;
        num    <= sum_sat;
        rem    <= '0;
        cnt    <= '0;
      end
      ST_DIV: begin
        // restoring division, quotient bits shift in behind the dividend
        num <= {num[SUM_BITS-2:0], unit_ge};
        if (cnt == CNT_BITS'(DIV_LAST)) begin
          rem  <= '0;
          root <= '0;
          cnt  <= '0;
        end else begin
          rem <= REM_BITS'(unit_ge ? unit_diff[HOP_BITS-1:0] : unit_a[HOP_BITS-1:0]);
          cnt <= cnt + 1'b1;
        end
      end
      ST_SQRT: begin
        // digit-by-digit root, two bits of the mean a step
        num  <= {num[SUM_BITS-3:0], 2'b00};
        rem  <= unit_ge ? unit_diff[REM_BITS-1:0] : unit_a[REM_BITS-1:0];
        root <= {root[ROOT_BITS-2:0], unit_ge};
        cnt  <= cnt + 1'b1;
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (out_load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      results.volume        <= out_vol;
      results.is_frame      <= out_frame;
      results.end_of_stream <= out_eos;
    end
  end

  // ---------------------------------------------------------------- assertions
  // a marker transaction carries no volume and always closes the stream
  assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.is_frame |-> results.volume == '0 && results.end_of_stream)
    else $error("end marker with volume or without end_of_stream");

  // the rounded root never goes past full scale
  assert property (@(posedge clk) disable iff (rst)
    results.valid && results.is_frame |-> results.volume <= VOL_BITS'(VOL_MAX))
    else $error("volume above full scale");

  // the divisor latched for a frame is never zero
  assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> hop_q != '0)
    else $error("division by a zero hop");

  // a result is only loaded into a free result register
  assert property (@(posedge clk) disable iff (rst)
    out_load |-> !results.valid || results.ready)
    else $error("result register overwritten while still full");

endmodule

// ----- tb/sv/frame_rms_volume_checker.sv -----
// ----------------------------------------------------------------------------
// frame_rms_volume_checker: volume prediction and result comparison
// follows hop_size writes on the apb port and every sample transaction,
// works out the rms volumes due and compares each result transaction with
// the oldest of them, field by field
// ----------------------------------------------------------------------------
module frame_rms_volume_checker import frv_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  frv_sample_if                    smp,
  frv_result_if                    res,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  input  logic                     pready,
  output int                       mismatches,
  output int                       outstanding,
  output int                       results_seen,
  output int                       markers_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [VOL_BITS-1:0] volume;
    logic                is_frame;
    logic                end_of_stream;
  } volume_t;

  localparam longint unsigned SUM_CAP = (64'd1 << SUM_BITS) - 64'd1;

  logic [HOP_BITS-1:0] hop_size;
  logic [SUM_BITS-1:0] square_acc;
  logic [HOP_BITS-1:0] fill;
  logic                fresh_stream;
  volume_t             volume_q[$];

  // rounded square root of floor(sum / hop), clipped to full scale
  function automatic logic [VOL_BITS-1:0] rms_volume(input longint unsigned sum,
                                                      input longint unsigned hop);
    longint unsigned mean;
    longint unsigned root;
    longint unsigned trial;
    mean = sum / hop;
    root = 0;
    for (int b = ROOT_BITS - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= mean) root = trial;
    end
    if (mean - root * root > root) root = root + 1;
    if (root > VOL_MAX) root = VOL_MAX;
    return root[VOL_BITS-1:0];
  endfunction

  function automatic void predict(input logic signed [SAMPLE_BITS-1:0] value,
                                  input logic last);
    longint          mag;
    longint unsigned sq;
    longint unsigned total;
    longint unsigned span;
    int              produced;
    volume_t         r;
    mag = value;
    if (mag < 0) mag = -mag;
    sq = mag * mag;
    span = (hop_size == 0) ? 1 : (hop_size > MAX_HOP) ? MAX_HOP : hop_size;
    produced = 0;
    // stream opens with frame 0, its own magnitude
    if (fresh_stream) begin
      volume_q.push_back('{rms_volume(sq, 1), 1'b1, 1'b0});
      produced++;
      fresh_stream = 1'b0;
    end
    total = square_acc + sq;
    if (total > SUM_CAP) total = SUM_CAP;
    square_acc = total[SUM_BITS-1:0];
    fill = fill + 1'b1;
    if (fill >= span) begin
      volume_q.push_back('{rms_volume(square_acc, span), 1'b1, 1'b0});
      produced++;
      square_acc = '0;
      fill = '0;
    end
    if (last) begin
      if (produced > 0) begin
        r = volume_q.pop_back();
        r.end_of_stream = 1'b1;
        volume_q.push_back(r);
      end else begin
        volume_q.push_back('{'0, 1'b0, 1'b1});
      end
      square_acc = '0;
      fill = '0;
      fresh_stream = 1'b1;
    end
  endfunction

  function automatic void check_result(input volume_t got);
    volume_t want;
    if (volume_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%t unexpected result: vol=%0d frame=%b eos=%b", $realtime,
                 got.volume, got.is_frame, got.end_of_stream);
    end else begin
      want = volume_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%t result mismatch: expected vol=%0d frame=%b eos=%b, ",
                    "got vol=%0d frame=%b eos=%b"},
                   $realtime, want.volume, want.is_frame, want.end_of_stream,
                   got.volume, got.is_frame, got.end_of_stream);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      hop_size = HOP_BITS'(HOP_RESET);
      square_acc = '0;
      fill = '0;
      fresh_stream = 1'b1;
      volume_q.delete();
      mismatches = 0;
      results_seen = 0;
      markers_seen = 0;
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr[APB_ADDR_BITS-1:REG_SEL_BIT] == REG_HOP_SIZE)
        hop_size = pwdata[HOP_BITS-1:0];
      if (smp.valid && smp.ready) predict(smp.sample, smp.stream_last);
      if (res.valid && res.ready) begin
        check_result('{res.volume, res.is_frame, res.end_of_stream});
        results_seen++;
        if (res.is_frame !== 1'b1) markers_seen++;
      end
    end
    outstanding = volume_q.size();
  end

endmodule

// ----- tb/sv/frame_rms_volume_unit_tb.sv -----
// ----------------------------------------------------------------------------
// frame_rms_volume_unit_tb: testbench top of the frame rms volume unit
// directed corner streams, a shrunk hop that clips the volume, then
// random streams under several hop sizes and idling phases; the checker
// beside the block predicts and compares, this module drives and judges
// ----------------------------------------------------------------------------
module frame_rms_volume_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import frv_pkg::*;

  // timing of the run
  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 100;
  localparam int IDLE_LIMIT    = 4000;  // cycles with no transaction at all
  localparam int RANDOM_ITEMS  = 832;
  localparam int SEGMENTS      = 8;

  // register index with nothing behind it
  localparam logic REG_UNMAPPED = 1'b1;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = ~SAMPLE_MIN;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  // idling knobs, percent of cycles
  int send_idle_pct = 0;
  int stall_pct     = 0;

  int samples_sent = 0;
  int hop_writes   = 0;
  int quiet_cycles = 0;

  int mismatches;
  int outstanding;
  int results_seen;
  int markers_seen;

  logic [APB_DATA_BITS-1:0] hop_plan [SEGMENTS];

  frv_sample_if smp_ch ();
  frv_result_if res_ch ();

  always #1 clk = ~clk;

  frame_rms_volume_unit dut (
    .clk     (clk),
    .rst     (rst),
    .samples (smp_ch),
    .results (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  frame_rms_volume_checker result_checker (
    .clk          (clk),
    .rst          (rst),
    .smp          (smp_ch),
    .res          (res_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen),
    .markers_seen (markers_seen)
  );

  // result side back-pressure, redrawn every falling edge
  always @(negedge clk) begin
    res_ch.ready = ($urandom_range(99) >= stall_pct);
  end

  // watchdog: any stretch with no transaction on either channel is bounded
  always @(posedge clk) begin
    if (rst || (smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("frame_rms_volume_unit verification failed");
      $finish;
    end
  end

  // one sample transaction, entered and left just after a falling edge;
  // valid stays high into the next call unless that call idles
  task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] value, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      smp_ch.valid = 1'b0;
      @(negedge clk);
    end
    smp_ch.valid       = 1'b1;
    smp_ch.sample      = value;
    smp_ch.stream_last = last;
    @(posedge clk);
    while (!smp_ch.ready) @(posedge clk);
    samples_sent++;
    @(negedge clk);
  endtask

  // setup cycle then access cycle; pready is tied high but honoured anyway
  task automatic apb_write(input logic index, input logic [APB_DATA_BITS-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = APB_ADDR_BITS'(index) << REG_SEL_BIT;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // wait for every due result, then for a sample still in work with none due
  task automatic drain();
    smp_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_hop(input logic [APB_DATA_BITS-1:0] data);
    drain();
    apb_write(REG_HOP_SIZE, data);
    hop_writes++;
  endtask

  // full-scale and near-zero values show up often, the rest is uniform
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return SAMPLE_MIN;
      1:       return SAMPLE_MAX;
      2:       return SAMPLE_BITS'(int'($urandom_range(8)) - 4);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  initial begin
    int span;
    int len;
    int left;
    smp_ch.valid       = 1'b0;
    smp_ch.sample      = '0;
    smp_ch.stream_last = 1'b0;
    res_ch.ready       = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;

    // hop sizes of the random segments, small ones mostly
    hop_plan[0] = 1;
    hop_plan[1] = 2;
    hop_plan[2] = 0;
    hop_plan[3] = 3;
    hop_plan[4] = $urandom_range(12, 4);
    hop_plan[5] = $urandom_range(64, 13);
    hop_plan[6] = 4;
    hop_plan[7] = $urandom_range(8, 1);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // default hop: negative full scale gives frame 0 of 32768, then a last
    // sample closing no frame gives a bare marker, then a one-sample stream
    // whose frame 0 carries the end flag
    push_sample(SAMPLE_MIN, 1'b0);
    push_sample(SAMPLE_MAX, 1'b1);
    push_sample('0, 1'b1);

    // hop of one: frame 0 and frame 1 from the first sample
    set_hop(1);
    push_sample(16'sd12345, 1'b0);
    push_sample(-16'sd1, 1'b1);

    // hop of zero behaves as one
    set_hop(0);
    push_sample(SAMPLE_MIN, 1'b1);

    // a complete frame, then a partial one dropped at the end
    set_hop(3);
    push_sample(16'sd100, 1'b0);
    push_sample(16'sd200, 1'b0);
    push_sample(16'sd300, 1'b0);
    push_sample(-16'sd5, 1'b1);

    // every register bit set clamps the hop to its maximum; a write beyond
    // the register map must leave it alone
    set_hop({APB_DATA_BITS{1'b1}});
    apb_write(REG_UNMAPPED, 1);
    repeat (5) push_sample(SAMPLE_MIN, 1'b0);

    // hop shrunk under a part-filled frame: it closes on the next sample and
    // the volume clips at full scale
    set_hop(2);
    push_sample(SAMPLE_MIN, 1'b1);

    // random streams, two hop settings in each idling phase
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      set_hop(hop_plan[seg]);
      case (seg / 2)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 63;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 63;
        end
        default: begin
          send_idle_pct = 21;
          stall_pct     = 21;
        end
      endcase
      span = (hop_plan[seg] == 0) ? 1 : int'(hop_plan[seg]);
      left = RANDOM_ITEMS / SEGMENTS;
      while (left > 0) begin
        // stream lengths around a few frames; now and then a stream runs on
        // into the next hop setting without its last mark
        len = $urandom_range(3 * span + 1, 1);
        if (len > left) len = left;
        for (int k = 0; k < len; k++)
          push_sample(pick_sample(), (k == len - 1) && ($urandom_range(5) != 0));
        left -= len;
      end
    end

    drain();

    $display("run covered %0d samples under %0d hop writes and four idling phases",
             samples_sent, hop_writes);
    $display("%0d results compared: %0d frames and %0d bare end markers",
             results_seen, results_seen - markers_seen, markers_seen);
    if (mismatches == 0)
      $display("frame_rms_volume_unit verification clean");
    else
      $display("frame_rms_volume_unit verification failed");
    $finish;
  end

endmodule
